// File: rtl/core/tpbp_pkg.sv
// tpbp_pkg: types, codes and the per-axis mapping function of the plane border padder
// no dependencies; imported by every module of the block

package tpbp_pkg;

  localparam int unsigned DEF_MAX_HEIGHT = 64;
  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_ELEM_BITS  = 64;

  localparam int unsigned CFG_BITS = 7;
  localparam int unsigned COORD_BITS = 8;
  localparam int unsigned IDX_BITS = 3;
  localparam int unsigned SGN_BITS = 11;

  typedef enum logic [1:0] {
    PAD_ZERO      = 2'd0,
    PAD_MIRROR    = 2'd1,
    PAD_REPLICATE = 2'd2,
    PAD_FOLD      = 2'd3
  } pad_mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_SOURCE = 2'd2
  } status_e;

  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_FETCH = 1'b1
  } req_type_e;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_MODE   = 3'd0,
    CFG_TOP    = 3'd1,
    CFG_BOTTOM = 3'd2,
    CFG_LEFT   = 3'd3,
    CFG_RIGHT  = 3'd4,
    CFG_HEIGHT = 3'd5,
    CFG_WIDTH  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    pad_mode_e           mode;
    logic [CFG_BITS-1:0] pad_top;
    logic [CFG_BITS-1:0] pad_bottom;
    logic [CFG_BITS-1:0] pad_left;
    logic [CFG_BITS-1:0] pad_right;
    logic [CFG_BITS-1:0] height;
    logic [CFG_BITS-1:0] width;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    req_type_e             req;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
  } in_t;

  typedef struct packed {
    logic                valid;
    logic                wr_en;
    logic                rd_en;
    logic                border;
    status_e             status;
    logic [CFG_BITS-1:0] src_row;
    logic [CFG_BITS-1:0] src_col;
  } acc_t;

  typedef struct packed {
    logic    valid;
    logic    rd_en;
    logic    border;
    status_e status;
  } res_t;

  typedef struct packed {
    logic                ok;
    logic [CFG_BITS-1:0] src;
  } axis_map_t;

  function automatic axis_map_t map_axis(input logic signed [SGN_BITS-1:0] i,
                                         input logic [CFG_BITS-1:0] len,
                                         input pad_mode_e mode);
    logic signed [SGN_BITS-1:0] l;
    logic signed [SGN_BITS-1:0] s;
    axis_map_t res;
    l = $signed({{(SGN_BITS-CFG_BITS){1'b0}}, len});
    s = i;
    if (i < 0) begin
      case (mode)
        PAD_MIRROR: s = -i;
        PAD_FOLD:   s = -i - 11'sd1;
        default:    s = '0;
      endcase
    end else if (i >= l) begin
      case (mode)
        PAD_MIRROR: s = (l <<< 1) - 11'sd2 - i;
        PAD_FOLD:   s = (l <<< 1) - 11'sd1 - i;
        default:    s = l - 11'sd1;
      endcase
    end
    res.ok  = (s >= 0) && (s < l);
    res.src = s[CFG_BITS-1:0];
    return res;
  endfunction

endpackage

// File: rtl/core/tpbp_map.sv
// tpbp_map: coordinate check and border mapping stage, registered
// depends on tpbp_pkg

module tpbp_map (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpbp_pkg::cfg_t cfg_i,
  input  tpbp_pkg::in_t  in_i,
  output tpbp_pkg::acc_t acc_o
);
  import tpbp_pkg::*;

  logic [CFG_BITS+1:0]        out_h;
  logic [CFG_BITS+1:0]        out_w;
  logic signed [SGN_BITS-1:0] ir;
  logic signed [SGN_BITS-1:0] ic;
  logic                       in_plane;
  axis_map_t                  mr;
  axis_map_t                  mc;
  acc_t                       acc_d;
  acc_t                       acc_q;

  always_comb begin
    out_h = 9'(cfg_i.pad_top) + 9'(cfg_i.height) + 9'(cfg_i.pad_bottom);
    out_w = 9'(cfg_i.pad_left) + 9'(cfg_i.width) + 9'(cfg_i.pad_right);
    ir = $signed(11'(in_i.row)) - $signed(11'(cfg_i.pad_top));
    ic = $signed(11'(in_i.col)) - $signed(11'(cfg_i.pad_left));
    in_plane = (ir >= 0) && (ir < $signed(11'(cfg_i.height)))
            && (ic >= 0) && (ic < $signed(11'(cfg_i.width)));
    mr = map_axis(ir, cfg_i.height, cfg_i.mode);
    mc = map_axis(ic, cfg_i.width, cfg_i.mode);

    acc_d.valid   = in_i.valid;
    acc_d.wr_en   = 1'b0;
    acc_d.rd_en   = 1'b0;
    acc_d.border  = 1'b0;
    acc_d.status  = ST_OK;
    acc_d.src_row = in_i.row[CFG_BITS-1:0];
    acc_d.src_col = in_i.col[CFG_BITS-1:0];

    if (in_i.req == REQ_STORE) begin
      if (in_i.row < 8'(cfg_i.height) && in_i.col < 8'(cfg_i.width)) begin
        acc_d.wr_en = in_i.valid;
      end else begin
        acc_d.status = ST_RANGE;
      end
    end else if (9'(in_i.row) >= out_h || 9'(in_i.col) >= out_w) begin
      acc_d.status = ST_RANGE;
    end else begin
      acc_d.src_row = mr.src;
      acc_d.src_col = mc.src;
      acc_d.border  = !in_plane;
      if (in_plane) begin
        acc_d.rd_en = in_i.valid;
      end else if (cfg_i.mode == PAD_ZERO) begin
        acc_d.rd_en = 1'b0;
      end else if (mr.ok && mc.ok) begin
        acc_d.rd_en = in_i.valid;
      end else begin
        acc_d.status = ST_SOURCE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/core/tpbp_store.sv
// tpbp_store: plane memory, one write or one registered read per cycle
// depends on tpbp_pkg

module tpbp_store #(
  parameter int unsigned MAX_HEIGHT = tpbp_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIDTH  = tpbp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned ELEM_BITS  = tpbp_pkg::DEF_ELEM_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tpbp_pkg::acc_t       acc_i,
  input  logic [ELEM_BITS-1:0] wr_data_i,
  output tpbp_pkg::res_t       res_o,
  output logic [ELEM_BITS-1:0] rd_data_o
);
  import tpbp_pkg::*;

  localparam int unsigned DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ELEM_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]        addr;
  logic [ELEM_BITS-1:0] rd_data_q;
  res_t                 res_d;
  res_t                 res_q;

  assign addr = AW'(32'(acc_i.src_row) * MAX_WIDTH + 32'(acc_i.src_col));

  always_ff @(posedge clk_i) begin
    if (acc_i.wr_en) begin
      mem[addr] <= wr_data_i;
    end
    if (acc_i.rd_en) begin
      rd_data_q <= mem[addr];
    end
  end

  always_comb begin
    res_d.valid  = acc_i.valid;
    res_d.rd_en  = acc_i.rd_en;
    res_d.border = acc_i.border;
    res_d.status = acc_i.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o     = res_q;
  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/tensor_plane_border_padder_top.sv
// tensor_plane_border_padder_top: top level, configuration registers and input stage
// depends on tpbp_pkg, tpbp_map, tpbp_store
//
// channel   direction  handshake                     payload
// request   in         start high, busy low          req_type_i row_i col_i elem_in_i
// result    out        out_valid_o for one cycle     elem_out_o in_border_o status_o
// config    in         cfg_valid_i and cfg_ready_o   cfg_index_i cfg_data_i
//
// one transaction per cycle; busy stays low and cfg_ready_o stays high
// a result is registered in order in the input register, the mapping register and the memory port
// stores and fetches share the single memory port, so a fetch sees every earlier store
// reset clears the pipeline and configuration; the plane memory is not cleared
// the receiver cannot stall, so nothing is held back on the result side

module tensor_plane_border_padder_top #(
  parameter int unsigned MAX_HEIGHT = tpbp_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIDTH  = tpbp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned ELEM_BITS  = tpbp_pkg::DEF_ELEM_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type_i,
  input  logic [tpbp_pkg::COORD_BITS-1:0]   row_i,
  input  logic [tpbp_pkg::COORD_BITS-1:0]   col_i,
  input  logic [ELEM_BITS-1:0]              elem_in_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpbp_pkg::IDX_BITS-1:0]     cfg_index_i,
  input  logic [tpbp_pkg::CFG_BITS-1:0]     cfg_data_i,
  output logic                              out_valid_o,
  output logic [ELEM_BITS-1:0]              elem_out_o,
  output logic                              in_border_o,
  output logic [1:0]                        status_o
);
  import tpbp_pkg::*;

  localparam int unsigned HCAP = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
  localparam int unsigned WCAP = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;

  cfg_t                 cfg_q;
  cfg_t                 cfg_d;
  cfg_t                 cfg_eff;
  in_t                  in_q;
  in_t                  in_d;
  logic [ELEM_BITS-1:0] elem_q;
  logic [ELEM_BITS-1:0] elem2_q;
  acc_t                 acc;
  res_t                 res;
  logic [ELEM_BITS-1:0] rd_data;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:   cfg_d.mode       = pad_mode_e'(cfg_data_i[1:0]);
        CFG_TOP:    cfg_d.pad_top    = cfg_data_i;
        CFG_BOTTOM: cfg_d.pad_bottom = cfg_data_i;
        CFG_LEFT:   cfg_d.pad_left   = cfg_data_i;
        CFG_RIGHT:  cfg_d.pad_right  = cfg_data_i;
        CFG_HEIGHT: cfg_d.height     = cfg_data_i;
        CFG_WIDTH:  cfg_d.width      = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    cfg_eff = cfg_q;
    if (cfg_q.height == '0) begin
      cfg_eff.height = 7'd1;
    end else if (cfg_q.height > 7'(HCAP)) begin
      cfg_eff.height = 7'(HCAP);
    end
    if (cfg_q.width == '0) begin
      cfg_eff.width = 7'd1;
    end else if (cfg_q.width > 7'(WCAP)) begin
      cfg_eff.width = 7'(WCAP);
    end
  end

  always_comb begin
    in_d.valid = start && !busy;
    in_d.req   = req_type_e'(req_type_i);
    in_d.row   = row_i;
    in_d.col   = col_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: PAD_ZERO, pad_top: '0, pad_bottom: '0, pad_left: '0,
                 pad_right: '0, height: 7'd1, width: 7'd1};
      in_q  <= '0;
    end else begin
      cfg_q <= cfg_d;
      in_q  <= in_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q  <= elem_in_i;
    elem2_q <= elem_q;
  end

  tpbp_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_eff),
    .in_i   (in_q),
    .acc_o  (acc)
  );

  tpbp_store #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .ELEM_BITS  (ELEM_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .wr_data_i (elem2_q),
    .res_o     (res),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = res.valid;
  assign elem_out_o  = res.rd_en ? rd_data : '0;
  assign in_border_o = res.border;
  assign status_o    = res.status;

endmodule

// File: rtl/core/tpbp_checker.sv
// tpbp_checker: port-level assertions for the plane border padder, bound to the top level
// depends on tpbp_pkg and tensor_plane_border_padder_top

module tpbp_checker #(
  parameter int unsigned ELEM_BITS = tpbp_pkg::DEF_ELEM_BITS
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            req_type_i,
  input logic                            out_valid_o,
  input logic [ELEM_BITS-1:0]            elem_out_o,
  input logic                            in_border_o,
  input logic [1:0]                      status_o
);
  import tpbp_pkg::*;

  // every accepted transaction gives one result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 out_valid_o)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, 3))
    else $error("result without a transaction");

  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_RANGE) |-> (!in_border_o && elem_out_o == '0))
    else $error("out of range result carries data");

  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(req_type_i == REQ_STORE, 3)) |->
      (!in_border_o && elem_out_o == '0 && status_o != ST_SOURCE))
    else $error("store result carries fetch data");

endmodule

bind tensor_plane_border_padder_top tpbp_checker #(.ELEM_BITS(ELEM_BITS)) u_tpbp_checker (.*);

// File: tb/sv/tb_tensor_plane_border_padder_top.sv
// tb_tensor_plane_border_padder_top: self-checking testbench for the plane border padder
// depends on tpbp_pkg and tensor_plane_border_padder_top; predicts every store and padded fetch
// from its own copy of the plane and the padding registers and checks each result in order

`timescale 1ns / 1ps

module tb_tensor_plane_border_padder_top;
  import tpbp_pkg::*;

  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int ELEM_W = DEF_ELEM_BITS;
  localparam int LATENCY = 3;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 155;
  localparam logic [IDX_BITS-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              border;
    status_e           st;
  } padded_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  req_type_i = 1'b0;
  logic [COORD_BITS-1:0] row_i = '0;
  logic [COORD_BITS-1:0] col_i = '0;
  logic [ELEM_W-1:0]     elem_in_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [IDX_BITS-1:0]   cfg_index_i = '0;
  logic [CFG_BITS-1:0]   cfg_data_i = '0;
  logic                  out_valid_o;
  logic [ELEM_W-1:0]     elem_out_o;
  logic                  in_border_o;
  logic [1:0]            status_o;

  pad_mode_e           cfg_mode = PAD_ZERO;
  logic [CFG_BITS-1:0] cfg_top = '0;
  logic [CFG_BITS-1:0] cfg_bottom = '0;
  logic [CFG_BITS-1:0] cfg_left = '0;
  logic [CFG_BITS-1:0] cfg_right = '0;
  logic [CFG_BITS-1:0] cfg_height = 7'd1;
  logic [CFG_BITS-1:0] cfg_width = 7'd1;

  logic [ELEM_W-1:0] plane_model [MAX_H*MAX_W];
  bit                written [MAX_H*MAX_W];
  padded_result_t    pending_pad_results [$];
  pad_mode_e         mode_list [4] = '{PAD_ZERO, PAD_MIRROR, PAD_REPLICATE, PAD_FOLD};
  bit                back_to_back = 1'b0;
  int                mismatch_count = 0;

  tensor_plane_border_padder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .elem_in_i   (elem_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .elem_out_o  (elem_out_o),
    .in_border_o (in_border_o),
    .status_o    (status_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int clamp_dim(input logic [CFG_BITS-1:0] v, input int lim);
    int d;
    d = int'(v);
    if (d < 1) d = 1;
    if (d > lim) d = lim;
    return d;
  endfunction

  function automatic bit mirror_axis(input int i, input int len, input pad_mode_e md,
                                     output int src);
    int s;
    s = i;
    if (i < 0) begin
      case (md)
        PAD_MIRROR: s = -i;
        PAD_FOLD:   s = -i - 1;
        default:    s = 0;
      endcase
    end else if (i >= len) begin
      case (md)
        PAD_MIRROR: s = 2 * (len - 1) - i;
        PAD_FOLD:   s = 2 * len - 1 - i;
        default:    s = len - 1;
      endcase
    end
    src = s;
    return (s >= 0) && (s < len);
  endfunction

  // addr is the plane entry read by the fetch, or -1 when nothing is read
  function automatic void resolve_fetch(input logic [COORD_BITS-1:0] row,
                                        input logic [COORD_BITS-1:0] col,
                                        output int addr, output logic border,
                                        output status_e st);
    int h, w, oh, ow, r, c, ir, ic, sr, sc;
    h = clamp_dim(cfg_height, MAX_H);
    w = clamp_dim(cfg_width, MAX_W);
    oh = int'(cfg_top) + h + int'(cfg_bottom);
    ow = int'(cfg_left) + w + int'(cfg_right);
    r = int'(row);
    c = int'(col);
    addr = -1;
    border = 1'b0;
    st = ST_OK;
    if (r >= oh || c >= ow) begin
      st = ST_RANGE;
    end else begin
      ir = r - int'(cfg_top);
      ic = c - int'(cfg_left);
      if (ir >= 0 && ir < h && ic >= 0 && ic < w) begin
        addr = ir * MAX_W + ic;
      end else begin
        border = 1'b1;
        if (cfg_mode != PAD_ZERO) begin
          if (mirror_axis(ir, h, cfg_mode, sr) && mirror_axis(ic, w, cfg_mode, sc))
            addr = sr * MAX_W + sc;
          else
            st = ST_SOURCE;
        end
      end
    end
  endfunction

  task automatic predict_padded(input req_type_e req, input logic [COORD_BITS-1:0] row,
                                input logic [COORD_BITS-1:0] col,
                                input logic [ELEM_W-1:0] elem);
    padded_result_t res;
    int addr;
    logic bd;
    status_e st;
    res.elem = '0;
    res.border = 1'b0;
    res.st = ST_OK;
    if (req == REQ_STORE) begin
      if (int'(row) < clamp_dim(cfg_height, MAX_H) && int'(col) < clamp_dim(cfg_width, MAX_W))
      begin
        plane_model[int'(row) * MAX_W + int'(col)] = elem;
        written[int'(row) * MAX_W + int'(col)] = 1'b1;
      end else begin
        res.st = ST_RANGE;
      end
    end else begin
      resolve_fetch(row, col, addr, bd, st);
      res.border = bd;
      res.st = st;
      if (addr >= 0) res.elem = plane_model[addr];
    end
    pending_pad_results.push_back(res);
  endtask

  task automatic send_item(input req_type_e req, input logic [COORD_BITS-1:0] row,
                           input logic [COORD_BITS-1:0] col,
                           input logic [ELEM_W-1:0] elem);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= req;
    row_i <= row;
    col_i <= col;
    elem_in_i <= elem;
    do @(posedge clk_i); while (busy);
    predict_padded(req, row, col, elem);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_pad_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:   cfg_mode = pad_mode_e'(data[1:0]);
      CFG_TOP:    cfg_top = data;
      CFG_BOTTOM: cfg_bottom = data;
      CFG_LEFT:   cfg_left = data;
      CFG_RIGHT:  cfg_right = data;
      CFG_HEIGHT: cfg_height = data;
      CFG_WIDTH:  cfg_width = data;
      default:    ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_padding(input logic [CFG_BITS-1:0] mode_data,
                                 input logic [CFG_BITS-1:0] top,
                                 input logic [CFG_BITS-1:0] bottom,
                                 input logic [CFG_BITS-1:0] left,
                                 input logic [CFG_BITS-1:0] right,
                                 input logic [CFG_BITS-1:0] height,
                                 input logic [CFG_BITS-1:0] width);
    drain();
    write_reg(CFG_MODE, mode_data);
    write_reg(CFG_TOP, top);
    write_reg(CFG_BOTTOM, bottom);
    write_reg(CFG_LEFT, left);
    write_reg(CFG_RIGHT, right);
    write_reg(CFG_HEIGHT, height);
    write_reg(CFG_WIDTH, width);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    padded_result_t exp_res;
    if (rst_ni && out_valid_o) begin
      if (pending_pad_results.size() == 0) begin
        report_mismatch("result with no pending transaction");
      end else begin
        exp_res = pending_pad_results.pop_front();
        if (elem_out_o !== exp_res.elem || in_border_o !== exp_res.border ||
            status_o !== exp_res.st)
          report_mismatch($sformatf("elem %h exp %h, border %b exp %b, status %0d exp %0d",
                                    elem_out_o, exp_res.elem, in_border_o, exp_res.border,
                                    status_o, exp_res.st));
      end
    end
  end

  task automatic test_reset_defaults;
    send_item(REQ_STORE, 8'd0, 8'd0, '1);
    send_item(REQ_FETCH, 8'd0, 8'd0, {$urandom, $urandom});
    send_item(REQ_STORE, 8'd1, 8'd0, {$urandom, $urandom});
    send_item(REQ_FETCH, 8'd255, 8'd255, '0);
  endtask

  task automatic test_padding_modes;
    program_padding(7'(PAD_ZERO), 7'd1, 7'd2, 7'd2, 7'd1, 7'd2, 7'd3);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++)
        send_item(REQ_STORE, 8'(r), 8'(c), {$urandom, $urandom});
    send_item(REQ_FETCH, 8'd1, 8'd2, '0);
    send_item(REQ_FETCH, 8'd5, 8'd0, '0);
    foreach (mode_list[m]) begin
      drain();
      write_reg(CFG_MODE, 7'(mode_list[m]));
      // corner, bottom-right beyond one mirror, left edge two rows below
      send_item(REQ_FETCH, 8'd0, 8'd0, '0);
      send_item(REQ_FETCH, 8'd4, 8'd5, '0);
      send_item(REQ_FETCH, 8'd3, 8'd0, '0);
    end
  endtask

  task automatic test_plane_saturation;
    program_padding(7'(PAD_REPLICATE), 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd127);
    send_item(REQ_STORE, 8'd0, 8'd63, '0);
    send_item(REQ_FETCH, 8'd0, 8'd64, '0);
    drain();
    write_reg(CFG_UNUSED, 7'h7f);
    send_item(REQ_FETCH, 8'd0, 8'd63, '1);
  endtask

  function automatic logic [CFG_BITS-1:0] pick_pad;
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'd127;
      3:       return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_size;
    case ($urandom_range(0, 7))
      0:       return 7'd64;
      1:       return 7'd0;
      2:       return 7'($urandom_range(65, 127));
      3:       return 7'($urandom_range(1, 64));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic test_random_traffic;
    int h, w, row_hi, col_hi, kind, addr;
    req_type_e req;
    logic [COORD_BITS-1:0] row, col;
    logic [ELEM_W-1:0] elem;
    logic bd;
    status_e st;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_padding({5'($urandom), 2'(mode_list[p % 4])},
                           7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64);
        1: program_padding({5'($urandom), 2'(mode_list[p % 4])},
                           7'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd1);
        2: program_padding({5'($urandom), 2'(mode_list[p % 4])},
                           7'd127, 7'd127, 7'd127, 7'd127, 7'd0, 7'd127);
        default: program_padding({5'($urandom), 2'(mode_list[p % 4])},
                                 pick_pad(), pick_pad(), pick_pad(), pick_pad(),
                                 pick_size(), pick_size());
      endcase
      h = clamp_dim(cfg_height, MAX_H);
      w = clamp_dim(cfg_width, MAX_W);
      row_hi = int'(cfg_top) + h + int'(cfg_bottom) - 1;
      col_hi = int'(cfg_left) + w + int'(cfg_right) - 1;
      if (row_hi > 255) row_hi = 255;
      if (col_hi > 255) col_hi = 255;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) back_to_back = ($urandom_range(0, 2) == 0);
        kind = $urandom_range(0, 9);
        elem = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) elem = '1;
        else if ($urandom_range(0, 15) == 0) elem = '0;
        if (kind <= 2) begin
          req = REQ_STORE;
          row = 8'($urandom_range(0, h - 1));
          col = 8'($urandom_range(0, w - 1));
        end else if (kind == 3) begin
          req = REQ_STORE;
          row = 8'($urandom_range(0, 255));
          col = 8'($urandom_range(0, 255));
        end else if (kind <= 8) begin
          req = REQ_FETCH;
          row = 8'($urandom_range(0, row_hi));
          col = 8'($urandom_range(0, col_hi));
        end else begin
          req = REQ_FETCH;
          row = 8'($urandom_range(0, 255));
          col = 8'($urandom_range(0, 255));
        end
        // never read an entry of the plane that has not been stored yet
        if (req == REQ_FETCH) begin
          resolve_fetch(row, col, addr, bd, st);
          if (addr >= 0 && !written[addr]) begin
            req = REQ_STORE;
            row = 8'(addr / MAX_W);
            col = 8'(addr % MAX_W);
          end
        end
        send_item(req, row, col, elem);
      end
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_reset_defaults();
    test_padding_modes();
    test_plane_saturation();
    test_random_traffic();
    drain();
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
